>>> sv/c39_pkg.sv
// Shared types, segment codes and character pattern table for the Code 39 encoder.
// No dependencies; every other file refers to it by scoped names.
package c39_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       first_char;
        logic       last_char;
    } c39_in_t;

    typedef struct packed {
        logic [12:0] module_bits;
        logic [3:0]  bit_count;
        logic        is_last;
        logic        bad_char;
        logic [12:0] width_dots;
    } c39_out_t;

    typedef struct packed {
        logic [9:0] module_count;
        logic [6:0] char_count;
        logic       aborted;
    } c39_state_t;

    typedef struct packed {
        c39_out_t   seg;
        logic       is_final;
        logic       drop;
        c39_state_t next_state;
    } c39_step_t;

    localparam int unsigned CHAR_COUNT_W = 7;
    localparam int unsigned SEG_W        = 3;

    localparam logic [SEG_W-1:0] SEG_QUIET4 = 3'd0;
    localparam logic [SEG_W-1:0] SEG_START  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_CHAR   = 3'd2;
    localparam logic [SEG_W-1:0] SEG_STOP   = 3'd3;
    localparam logic [SEG_W-1:0] SEG_QUIET8 = 3'd4;

    localparam logic [11:0] GUARD_PAT      = 12'h96D;
    localparam logic [3:0]  DOTS_RESET     = 4'd2;
    localparam logic [12:0] WIDTH_MAX      = 13'h1FFF;
    localparam logic [9:0]  LEAD_MODULES   = 10'd17;
    localparam logic [9:0]  CHAR_MODULES   = 10'd13;
    localparam logic [9:0]  TRAIL_MODULES  = 10'd20;

    localparam logic [11:0] DIGIT_PAT [10] = '{
        12'hA6D, 12'hD2B, 12'hB2B, 12'hD95, 12'hA6B,
        12'hD35, 12'hB35, 12'hA5B, 12'hD2D, 12'hB2D
    };

    localparam logic [11:0] ALPHA_PAT [26] = '{
        12'hD4B, 12'hB4B, 12'hDA5, 12'hACB, 12'hD65, 12'hB65, 12'hA9B, 12'hD4D,
        12'hB4D, 12'hACD, 12'hD53, 12'hB53, 12'hDA9, 12'hAD3, 12'hD69, 12'hB69,
        12'hAB3, 12'hD59, 12'hB59, 12'hAD9, 12'hCAB, 12'h9AB, 12'hCD5, 12'h96B,
        12'hCB5, 12'h9B5
    };

    // zero means the character has no encoding
    function automatic logic [11:0] pattern_of(input logic [7:0] c);
        logic [7:0]  di;
        logic [7:0]  ai;
        logic [11:0] pat;
        di  = c - 8'h30;
        ai  = c - 8'h41;
        pat = 12'h000;
        if (c inside {[8'h30:8'h39]})
        begin
            pat = DIGIT_PAT[di[3:0]];
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            pat = ALPHA_PAT[ai[4:0]];
        end
        else
        begin
            case (c)
                8'h2D:   pat = 12'h95B;
                8'h2E:   pat = 12'hCAD;
                8'h20:   pat = 12'h9AD;
                8'h24:   pat = 12'h925;
                8'h2F:   pat = 12'h929;
                8'h2B:   pat = 12'h949;
                8'h25:   pat = 12'hA49;
                default: pat = 12'h000;
            endcase
        end
        return pat;
    endfunction

endpackage

>>> sv/c39_seg_sel.sv
// Segment selection for one held character: picks the current segment, final flag and
// the symbol state that follows the character. Depends on c39_pkg.
module c39_seg_sel #(
    parameter int unsigned MAX_CHARS = 64
) (
    input  c39_pkg::c39_in_t        item,
    input  c39_pkg::c39_state_t     state,
    input  logic [3:0]              dots_per_module,
    input  logic [c39_pkg::SEG_W-1:0] seg_idx,
    output c39_pkg::c39_step_t      step
);

    logic [11:0]                      pat;
    logic [c39_pkg::SEG_W-1:0]        pos;
    logic [c39_pkg::SEG_W-1:0]        final_pos;
    logic [c39_pkg::CHAR_COUNT_W-1:0] eff_cc;
    logic [9:0]                       mc_base;
    logic [9:0]                       mc_end;
    logic [13:0]                      product;
    logic [12:0]                      width;
    logic                             bad;

    assign pat       = c39_pkg::pattern_of(item.character);
    assign pos       = seg_idx + (item.first_char ? c39_pkg::SEG_QUIET4 : c39_pkg::SEG_CHAR);
    assign final_pos = item.last_char ? c39_pkg::SEG_QUIET8 : c39_pkg::SEG_CHAR;
    assign eff_cc    = item.first_char ? '0 : state.char_count;
    assign mc_base   = item.first_char ? '0 : state.module_count;
    assign mc_end    = mc_base
                     + (item.first_char ? c39_pkg::LEAD_MODULES : 10'd0)
                     + c39_pkg::CHAR_MODULES
                     + (item.last_char ? c39_pkg::TRAIL_MODULES : 10'd0);
    assign product   = 14'(mc_end) * 14'(dots_per_module);
    assign width     = (product > 14'(c39_pkg::WIDTH_MAX)) ? c39_pkg::WIDTH_MAX
                                                           : product[12:0];
    assign bad       = (pat == 12'h000)
                    || (eff_cc >= c39_pkg::CHAR_COUNT_W'(MAX_CHARS));

    always_comb
    begin
        step                 = '0;
        step.drop            = !item.first_char && state.aborted;
        step.is_final        = bad || (pos == final_pos);
        if (bad)
        begin
            step.seg.bit_count = 4'd1;
            step.seg.bad_char  = 1'b1;
        end
        else
        begin
            case (pos)
                c39_pkg::SEG_QUIET4:
                begin
                    step.seg.bit_count = 4'd4;
                end
                c39_pkg::SEG_START:
                begin
                    step.seg.module_bits = {c39_pkg::GUARD_PAT, 1'b0};
                    step.seg.bit_count   = 4'd13;
                end
                c39_pkg::SEG_CHAR:
                begin
                    step.seg.module_bits = {pat, 1'b0};
                    step.seg.bit_count   = 4'd13;
                end
                c39_pkg::SEG_STOP:
                begin
                    step.seg.module_bits = {1'b0, c39_pkg::GUARD_PAT};
                    step.seg.bit_count   = 4'd12;
                end
                c39_pkg::SEG_QUIET8:
                begin
                    step.seg.bit_count  = 4'd8;
                    step.seg.width_dots = width;
                end
                default:
                begin
                    step.seg.bit_count = 4'd1;
                end
            endcase
        end
        step.seg.is_last = step.is_final;

        if (bad)
        begin
            step.next_state.module_count = mc_base;
            step.next_state.char_count   = eff_cc;
            step.next_state.aborted      = 1'b1;
        end
        else
        begin
            step.next_state.module_count = mc_end;
            step.next_state.char_count   = eff_cc + c39_pkg::CHAR_COUNT_W'(1);
            step.next_state.aborted      = item.last_char;
        end
    end

endmodule

>>> sv/code39_symbol_encoder.sv
// Code 39 encoder top level: holds one character beat, emits its segments in order,
// and keeps the symbol state and dots_per_module. Depends on c39_pkg, c39_seg_sel.
// Each segment of a character is registered in out_data_reg after the beat is held in item_reg.
// Throughput: one segment per cycle unless out_stall holds the output; a character gives 1 to 5
// segments (none if ignored) through the single output register; the next beat is taken with the last one.
// Reset: empty pipeline, counts zero, waiting for a first character, dots_per_module = 2.
module code39_symbol_encoder #(
    parameter int unsigned MAX_CHARS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  c39_pkg::c39_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output c39_pkg::c39_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data
);

    c39_pkg::c39_in_t          item_reg;
    logic                      item_valid_reg;
    logic [c39_pkg::SEG_W-1:0] seg_reg;
    logic [c39_pkg::SEG_W-1:0] seg_next;
    c39_pkg::c39_state_t       state_reg;
    logic [3:0]                dots_reg;
    logic                      out_valid_reg;
    c39_pkg::c39_out_t         out_data_reg;
    c39_pkg::c39_step_t        step;
    logic                      out_free;
    logic                      emit;
    logic                      item_done;
    logic                      in_take;

    c39_seg_sel #(
        .MAX_CHARS (MAX_CHARS)
    ) u_seg_sel (
        .item            (item_reg),
        .state           (state_reg),
        .dots_per_module (dots_reg),
        .seg_idx         (seg_reg),
        .step            (step)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = item_valid_reg && !step.drop && out_free;
    assign item_done = item_valid_reg && (step.drop || (emit && step.is_final));
    assign in_stall  = item_valid_reg && !item_done;
    assign in_take   = in_valid && !in_stall;
    assign seg_next  = (emit && step.is_final) ? '0
                     : (emit ? seg_reg + c39_pkg::SEG_W'(1) : seg_reg);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg         <= 1'b0;
            seg_reg                <= '0;
            state_reg.module_count <= '0;
            state_reg.char_count   <= '0;
            state_reg.aborted      <= 1'b1;
            dots_reg               <= c39_pkg::DOTS_RESET;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            if (emit && step.is_final)
            begin
                state_reg <= step.next_state;
            end
            if (cfg_valid && cfg_ready)
            begin
                dots_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        if (emit)
        begin
            out_data_reg <= step.seg;
        end
    end

endmodule

>>> sv/c39_checker.sv
// Port-level checks for the Code 39 encoder, attached to the top level by bind.
// Depends on c39_pkg and code39_symbol_encoder.
module c39_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input c39_pkg::c39_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.bit_count != 4'd0) && (out_data.bit_count <= 4'd13))
        else $error("bit_count out of range");

    a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_char |-> out_data.is_last
            && (out_data.bit_count == 4'd1) && (out_data.module_bits == 13'd0)
            && (out_data.width_dots == 13'd0))
        else $error("malformed abort result");

    a_width_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_last |-> (out_data.width_dots == 13'd0))
        else $error("width reported before final result");

endmodule

bind code39_symbol_encoder c39_checker u_c39_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/tb_code39_symbol_encoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for code39_symbol_encoder: directed table, then random messages.
// Depends on c39_pkg for the beat types; predicts every segment and compares it in order.
module tb_code39_symbol_encoder;

    localparam int MAX_MSG_CHARS = 64;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 120;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [11:0] GUARD_BARS = 12'h96D;

    localparam logic [11:0] BAR_DIGITS [10] = '{
        12'hA6D, 12'hD2B, 12'hB2B, 12'hD95, 12'hA6B,
        12'hD35, 12'hB35, 12'hA5B, 12'hD2D, 12'hB2D
    };

    localparam logic [11:0] BAR_LETTERS [26] = '{
        12'hD4B, 12'hB4B, 12'hDA5, 12'hACB, 12'hD65, 12'hB65, 12'hA9B, 12'hD4D,
        12'hB4D, 12'hACD, 12'hD53, 12'hB53, 12'hDA9, 12'hAD3, 12'hD69, 12'hB69,
        12'hAB3, 12'hD59, 12'hB59, 12'hAD9, 12'hCAB, 12'h9AB, 12'hCD5, 12'h96B,
        12'hCB5, 12'h9B5
    };

    localparam c39_pkg::c39_out_t ABORT_BEAT = '{
        module_bits: 13'd0, bit_count: 4'd1, is_last: 1'b1, bad_char: 1'b1,
        width_dots: 13'd0
    };

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_ABORT
    } row_kind_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
        row_kind_e  kind;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{"A",   1'b0, 1'b0, ROW_NONE},
        '{8'hFF, 1'b1, 1'b0, ROW_ABORT},
        '{"Z",   1'b0, 1'b1, ROW_NONE},
        '{"0",   1'b1, 1'b1, ROW_MODEL},
        '{"9",   1'b1, 1'b0, ROW_MODEL},
        '{"-",   1'b0, 1'b0, ROW_MODEL},
        '{".",   1'b0, 1'b0, ROW_MODEL},
        '{" ",   1'b0, 1'b0, ROW_MODEL},
        '{"$",   1'b0, 1'b0, ROW_MODEL},
        '{"/",   1'b0, 1'b0, ROW_MODEL},
        '{"+",   1'b0, 1'b0, ROW_MODEL},
        '{"%",   1'b0, 1'b1, ROW_MODEL},
        '{"Q",   1'b0, 1'b1, ROW_NONE},
        '{8'h00, 1'b1, 1'b1, ROW_ABORT},
        '{"B",   1'b1, 1'b0, ROW_MODEL},
        '{"C",   1'b0, 1'b0, ROW_MODEL},
        '{"D",   1'b1, 1'b0, ROW_MODEL},
        '{"E",   1'b0, 1'b1, ROW_MODEL},
        '{"K",   1'b1, 1'b0, ROW_MODEL},
        '{8'h61, 1'b0, 1'b0, ROW_ABORT},
        '{"L",   1'b0, 1'b1, ROW_NONE},
        '{8'h40, 1'b1, 1'b0, ROW_ABORT},
        '{8'h5B, 1'b1, 1'b1, ROW_ABORT},
        '{8'h3A, 1'b1, 1'b0, ROW_ABORT},
        '{"7",   1'b1, 1'b1, ROW_MODEL}
    };

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    c39_pkg::c39_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    c39_pkg::c39_out_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [3:0]        cfg_data  = 4'd0;

    logic       pressure_req = 1'b0;
    logic       hold_out     = 1'b0;

    logic [9:0] msg_modules = '0;
    logic [6:0] msg_chars   = '0;
    logic       waiting     = 1'b1;
    logic [3:0] dots        = c39_pkg::DOTS_RESET;

    c39_pkg::c39_out_t segment_q [$];
    int                fail_count = 0;

    int         tx_run  = 0;
    bit         tx_calm = 1'b0;
    int         rx_run  = 0;
    bit         rx_calm = 1'b0;

    code39_symbol_encoder #(
        .MAX_CHARS (MAX_MSG_CHARS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_gap(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(10, 30);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [11:0] bar_pattern(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return BAR_DIGITS[c - 8'h30];
        if (c >= 8'h41 && c <= 8'h5A)
            return BAR_LETTERS[c - 8'h41];
        case (c)
            "-":     return 12'h95B;
            ".":     return 12'hCAD;
            " ":     return 12'h9AD;
            "$":     return 12'h925;
            "/":     return 12'h929;
            "+":     return 12'h949;
            "%":     return 12'hA49;
            default: return 12'h000;
        endcase
    endfunction

    function automatic logic [7:0] any_code39_char();
        string charset;
        charset = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%";
        return charset[$urandom_range(0, 42)];
    endfunction

    function automatic c39_pkg::c39_out_t make_segment(input logic [12:0] bits,
                                                       input logic [3:0]  count);
        c39_pkg::c39_out_t seg;
        seg             = '0;
        seg.module_bits = bits;
        seg.bit_count   = count;
        return seg;
    endfunction

    // returns the number of segments the beat produces; queue them only when keep is set
    function automatic int encode_beat(input c39_pkg::c39_in_t beat, input bit keep);
        logic [11:0]       pat;
        logic [16:0]       wide;
        c39_pkg::c39_out_t segs [5];
        int                n;
        n = 0;
        if (beat.first_char)
        begin
            msg_modules = '0;
            msg_chars   = '0;
            waiting     = 1'b0;
        end
        else if (waiting)
        begin
            return 0;
        end
        pat = bar_pattern(beat.character);
        if (pat == 12'h000 || msg_chars >= MAX_MSG_CHARS)
        begin
            waiting = 1'b1;
            if (keep)
                segment_q.push_back(ABORT_BEAT);
            return 1;
        end
        if (beat.first_char)
        begin
            segs[n]     = make_segment(13'd0, 4'd4);
            n           = n + 1;
            segs[n]     = make_segment({GUARD_BARS, 1'b0}, 4'd13);
            n           = n + 1;
            msg_modules = msg_modules + 10'd17;
        end
        segs[n]     = make_segment({pat, 1'b0}, 4'd13);
        n           = n + 1;
        msg_modules = msg_modules + 10'd13;
        msg_chars   = msg_chars + 7'd1;
        if (beat.last_char)
        begin
            segs[n]     = make_segment({1'b0, GUARD_BARS}, 4'd12);
            n           = n + 1;
            segs[n]     = make_segment(13'd0, 4'd8);
            n           = n + 1;
            msg_modules = msg_modules + 10'd20;
            wide        = 17'(msg_modules) * 17'(dots);
            segs[n-1].width_dots = (wide > 17'd8191) ? 13'h1FFF : wide[12:0];
            waiting     = 1'b1;
        end
        segs[n-1].is_last = 1'b1;
        if (keep)
            for (int i = 0; i < n; i++)
                segment_q.push_back(segs[i]);
        return n;
    endfunction

    function automatic void check_segment(input c39_pkg::c39_out_t got);
        c39_pkg::c39_out_t want;
        if (segment_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected beat: bits=%h count=%0d last=%b bad=%b width=%0d",
                         got.module_bits, got.bit_count, got.is_last, got.bad_char,
                         got.width_dots);
            return;
        end
        want = segment_q.pop_front();
        if (got.module_bits !== want.module_bits || got.bit_count !== want.bit_count ||
            got.is_last !== want.is_last || got.bad_char !== want.bad_char ||
            got.width_dots !== want.width_dots)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display({"mismatch: exp bits=%h count=%0d last=%b bad=%b width=%0d",
                          " | got bits=%h count=%0d last=%b bad=%b width=%0d"},
                         want.module_bits, want.bit_count, want.is_last, want.bad_char,
                         want.width_dots, got.module_bits, got.bit_count, got.is_last,
                         got.bad_char, got.width_dots);
        end
    endfunction

    task automatic deliver(input c39_pkg::c39_in_t beat, input bit keep, output int produced);
        int gap;
        gap = draw_gap(tx_run, tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        produced = encode_beat(beat, keep);
    endtask

    task automatic set_dots(input logic [3:0] value);
        in_valid <= 1'b0;
        while (segment_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dots = value;
    endtask

    // mostly well-formed messages; some carry a bad byte, lose their end, or get a stray beat
    task automatic random_traffic(input int wanted);
        c39_pkg::c39_in_t beat;
        int               done;
        int               len;
        int               flaw;
        int               bad_pos;
        int               n;
        done = 0;
        while (done < wanted)
        begin
            flaw    = $urandom_range(0, 9);
            len     = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            bad_pos = $urandom_range(0, len - 1);
            if (flaw == 2)
            begin
                beat.character  = 8'($urandom_range(0, 255));
                beat.first_char = 1'b0;
                beat.last_char  = 1'($urandom_range(0, 1));
                deliver(beat, 1'b1, n);
                if (n > 0)
                    done++;
            end
            for (int i = 0; i < len; i++)
            begin
                beat.character  = (flaw == 0 && i == bad_pos) ? 8'($urandom_range(0, 255))
                                                             : any_code39_char();
                beat.first_char = (i == 0);
                beat.last_char  = (i == len - 1) && (flaw != 1);
                deliver(beat, 1'b1, n);
                if (n > 0)
                    done++;
            end
        end
    endtask

    initial
    begin
        int gap;
        forever
        begin
            gap = draw_gap(rx_run, rx_calm);
            if (gap > 0 || hold_out)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                while (hold_out) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            check_segment(out_data);
        end
    end

    initial
    begin
        while (!pressure_req) @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        c39_pkg::c39_in_t beat;
        int               n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            beat.character  = DIRECTED[i].ch;
            beat.first_char = DIRECTED[i].first;
            beat.last_char  = DIRECTED[i].last;
            deliver(beat, DIRECTED[i].kind == ROW_MODEL, n);
            if (DIRECTED[i].kind == ROW_ABORT)
                segment_q.push_back(ABORT_BEAT);
        end

        set_dots(4'd1);
        random_traffic(5);

        // full-length message at 8 dots per module, then one character too many
        set_dots(4'd8);
        for (int i = 0; i < MAX_MSG_CHARS; i++)
        begin
            beat.character  = any_code39_char();
            beat.first_char = (i == 0);
            beat.last_char  = (i == MAX_MSG_CHARS - 1);
            deliver(beat, 1'b1, n);
        end
        for (int i = 0; i <= MAX_MSG_CHARS; i++)
        begin
            beat.character  = any_code39_char();
            beat.first_char = (i == 0);
            beat.last_char  = 1'b0;
            deliver(beat, 1'b1, n);
        end
        random_traffic(5);

        set_dots(4'd5);
        pressure_req <= 1'b1;
        random_traffic(5);

        set_dots(4'd3);
        random_traffic(5);

        in_valid <= 1'b0;
        while (segment_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
sv/c39_pkg.sv
sv/c39_seg_sel.sv
sv/code39_symbol_encoder.sv
sv/c39_checker.sv
tb/tb_code39_symbol_encoder.sv
